[design/bffa_pkg.sv]
// Package: constants, types and status codes of the bitmap first-fit allocator.
`timescale 1ns / 1ps
`default_nettype none
package bffa_pkg;
	localparam int BitmapWords  = 32;
	localparam int TableEntries = 32;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TABLE     = 3'd1,
		ST_NO_RUN    = 3'd2,
		ST_HEAP_END  = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_BASE    = 2'd0,
		CFG_END     = 2'd1,
		CFG_CLUSTER = 2'd2,
		CFG_WORDS   = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_TSCAN, S_DIV, S_RDW, S_BSCAN, S_MUL, S_CHK,
		S_MARK_RD, S_MARK, S_FSCAN, S_FRD, S_OUT
	} state_t;
endpackage
`default_nettype wire

[design/bitmap_first_fit_allocator_unit.sv]
// Top level: bitmap first-fit heap allocator with a sequenced shared scan unit.
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | signals
// cfg     | in        | cfg_valid cfg_ready cfg_index cfg_data
// req     | in        | in_valid in_ready action request_bytes free_address
// rsp     | out       | out_valid out_ready block_address status
// An allocate scans the table for a free slot, divides the size rounded up by the
// cluster size in a restoring division, scans the bitmap for a free run, multiplies
// its start by the cluster size in a shift-add multiply, checks the heap end and
// marks the run; a free scans the table for the match and clears its run. The mark
// or clear pass takes a read state and a write state per cluster; refusals end earlier.
// Reset clears control state and valid bits; the bitmap is cleared by a sweep over
// its BITMAP_WORDS words after reset, before the first item is taken.
// The block holds one item; in_ready is low until the result beat is taken.
module bitmap_first_fit_allocator_unit #(
	parameter int BITMAP_WORDS  = bffa_pkg::BitmapWords,
	parameter int TABLE_ENTRIES = bffa_pkg::TableEntries
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [31:0] request_bytes,
	input  wire logic [31:0] free_address,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      block_address,
	output logic [2:0]       status
);
	localparam int WW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
	localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int PW = WW + 5;
	localparam int LW = PW + 1;
	localparam int TOTAL = BITMAP_WORDS * 32;

	bffa_pkg::state_t state_q, state_d;

	logic [31:0] heap_base_q, heap_end_q;
	logic [16:0] cluster_q;
	logic [5:0]  words_q;

	logic [31:0] bmem [BITMAP_WORDS];
	logic [31:0] rd_q;
	logic [31:0] wdata;
	logic        bwe;
	logic [WW-1:0] baddr;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [31:0]  eaddr_q [TABLE_ENTRIES];
	logic [PW-1:0] estart_q [TABLE_ENTRIES];
	logic [LW-1:0] elen_q [TABLE_ENTRIES];

	logic        clr_q;
	logic [WW:0] clr_cnt_q;

	logic [31:0] size_q, faddr_q;
	logic [TW:0] tcnt_q;
	logic [TW-1:0] slot_q;
	logic [32:0] rem_q;
	logic [32:0] quo_q;
	logic [5:0]  dcnt_q;
	logic [PW:0] pos_q;
	logic [PW:0] total_q;
	logic [PW-1:0] begin_q;
	logic [32:0] run_q;
	logic [32:0] prod_q;
	logic [PW:0] mcand_q;
	logic [4:0]  mcnt_q;
	logic [LW-1:0] mlen_q;
	logic [PW-1:0] mpos_q;
	logic        mset_q;
	logic [31:0] res_addr_q;
	logic [2:0]  res_st_q;
	logic        bit_here;

	logic [16:0] cb;
	assign cb = (cluster_q == 17'd0) ? 17'd1 : cluster_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == bffa_pkg::S_IDLE) && !clr_q;
	assign out_valid = (state_q == bffa_pkg::S_OUT);
	assign block_address = res_addr_q;
	assign status = res_st_q;

	logic [PW:0] wcap;
	assign wcap = ((PW+1)'(words_q) > (PW+1)'(BITMAP_WORDS)) ? (PW+1)'(BITMAP_WORDS * 32)
		: ((PW+1)'(words_q) << 5);

	assign bit_here = rd_q[pos_q[4:0]];

	logic [33:0] dsub;
	assign dsub = {rem_q, quo_q[32]} - {17'd0, cb};

	logic [32:0] endsum;
	assign endsum = {1'b0, heap_base_q} + prod_q;

	logic heap_over;
	assign heap_over = ({1'b0, endsum} + {2'b0, size_q}) > {2'b0, heap_end_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= '0;
			heap_end_q  <= '0;
			cluster_q   <= 17'd32;
			words_q     <= 6'd32;
		end else if (cfg_valid) begin
			case (bffa_pkg::cfg_idx_t'(cfg_index))
				bffa_pkg::CFG_BASE:    heap_base_q <= cfg_data;
				bffa_pkg::CFG_END:     heap_end_q  <= cfg_data;
				bffa_pkg::CFG_CLUSTER: cluster_q   <= cfg_data[16:0];
				bffa_pkg::CFG_WORDS:   words_q     <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// bitmap memory: one port, registered read
	always_ff @(posedge clk) begin
		if (bwe) begin
			bmem[baddr] <= wdata;
		end
		rd_q <= bmem[baddr];
	end

	always_comb begin
		bwe = 1'b0;
		wdata = rd_q;
		baddr = pos_q[PW-1:5];
		if (clr_q) begin
			bwe = 1'b1;
			wdata = '0;
			baddr = clr_cnt_q[WW-1:0];
		end else if (state_q == bffa_pkg::S_MARK_RD || state_q == bffa_pkg::S_MARK) begin
			baddr = mpos_q[PW-1:5];
			if (state_q == bffa_pkg::S_MARK) begin
				bwe = 1'b1;
				wdata = rd_q;
				wdata[mpos_q[4:0]] = mset_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == (WW+1)'(BITMAP_WORDS - 1)) begin
				clr_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bffa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bffa_pkg::S_IDLE:
				if (in_valid && in_ready) begin
					if (action == bffa_pkg::ACT_FREE) begin
						state_d = (free_address == 32'd0) ? bffa_pkg::S_OUT : bffa_pkg::S_FSCAN;
					end else begin
						state_d = (request_bytes == 32'd0) ? bffa_pkg::S_OUT : bffa_pkg::S_TSCAN;
					end
				end
			bffa_pkg::S_TSCAN:
				if (tcnt_q == (TW+1)'(TABLE_ENTRIES)) begin
					state_d = bffa_pkg::S_OUT;
				end else if (!valid_q[tcnt_q[TW-1:0]]) begin
					state_d = bffa_pkg::S_DIV;
				end
			bffa_pkg::S_DIV:
				if (dcnt_q == 6'd33) begin
					state_d = (total_q == '0) ? bffa_pkg::S_OUT : bffa_pkg::S_RDW;
				end
			bffa_pkg::S_RDW: state_d = bffa_pkg::S_BSCAN;
			bffa_pkg::S_BSCAN:
				if (!bit_here && (run_q + 33'd1 == quo_q)) begin
					state_d = bffa_pkg::S_MUL;
				end else if (pos_q + 1'b1 == total_q) begin
					state_d = bffa_pkg::S_OUT;
				end else if (pos_q[4:0] == 5'd31) begin
					state_d = bffa_pkg::S_RDW;
				end
			bffa_pkg::S_MUL:
				if (mcnt_q == 5'd17) begin
					state_d = bffa_pkg::S_CHK;
				end
			bffa_pkg::S_CHK:
				state_d = heap_over ? bffa_pkg::S_OUT : bffa_pkg::S_MARK_RD;
			bffa_pkg::S_MARK_RD:
				state_d = (mlen_q == '0 || {1'b0, mpos_q} >= (PW+1)'(TOTAL))
					? bffa_pkg::S_OUT : bffa_pkg::S_MARK;
			bffa_pkg::S_MARK: state_d = bffa_pkg::S_MARK_RD;
			bffa_pkg::S_FSCAN:
				if (tcnt_q == (TW+1)'(TABLE_ENTRIES)) begin
					state_d = bffa_pkg::S_OUT;
				end else if (valid_q[tcnt_q[TW-1:0]] && eaddr_q[tcnt_q[TW-1:0]] == faddr_q) begin
					state_d = bffa_pkg::S_FRD;
				end
			bffa_pkg::S_FRD: state_d = bffa_pkg::S_MARK_RD;
			bffa_pkg::S_OUT:
				if (out_ready) begin
					state_d = bffa_pkg::S_IDLE;
				end
			default: state_d = bffa_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			res_st_q <= bffa_pkg::ST_OK;
			res_addr_q <= '0;
		end else begin
			case (state_q)
				bffa_pkg::S_IDLE:
					if (in_valid && in_ready) begin
						res_addr_q <= '0;
						res_st_q <= bffa_pkg::ST_NOT_FOUND;
					end
				bffa_pkg::S_TSCAN:
					if (tcnt_q == (TW+1)'(TABLE_ENTRIES)) begin
						res_st_q <= bffa_pkg::ST_TABLE;
					end
				bffa_pkg::S_DIV:
					if (dcnt_q == 6'd33) begin
						res_st_q <= bffa_pkg::ST_NO_RUN;
					end
				bffa_pkg::S_CHK:
					if (heap_over) begin
						res_st_q <= bffa_pkg::ST_HEAP_END;
					end else begin
						res_st_q <= bffa_pkg::ST_OK;
						res_addr_q <= endsum[31:0];
						valid_q[slot_q] <= 1'b1;
					end
				bffa_pkg::S_FRD: begin
					res_st_q <= bffa_pkg::ST_OK;
					valid_q[slot_q] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bffa_pkg::S_IDLE: begin
				size_q <= request_bytes;
				faddr_q <= free_address;
				tcnt_q <= '0;
			end
			bffa_pkg::S_TSCAN: begin
				slot_q <= tcnt_q[TW-1:0];
				tcnt_q <= tcnt_q + 1'b1;
				quo_q <= {1'b0, size_q} + 33'(cb) - 33'd1;
				rem_q <= '0;
				dcnt_q <= '0;
				total_q <= wcap;
			end
			bffa_pkg::S_DIV: begin
				// restoring division of size + cb - 1 by cb, one bit a cycle
				if (dcnt_q != 6'd33) begin
					if (!dsub[33]) begin
						rem_q <= dsub[32:0];
						quo_q <= {quo_q[31:0], 1'b1};
					end else begin
						rem_q <= {rem_q[31:0], quo_q[32]};
						quo_q <= {quo_q[31:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 1'b1;
				end
				pos_q <= '0;
				run_q <= '0;
			end
			bffa_pkg::S_BSCAN: begin
				if (bit_here) begin
					run_q <= '0;
				end else begin
					if (run_q == '0) begin
						begin_q <= pos_q[PW-1:0];
					end
					run_q <= run_q + 33'd1;
				end
				pos_q <= pos_q + 1'b1;
				prod_q <= '0;
				mcand_q <= (run_q == '0) ? pos_q : {1'b0, begin_q};
				mcnt_q <= '0;
			end
			bffa_pkg::S_MUL: begin
				// shift-add multiply of start by cluster size
				if (mcnt_q != 5'd17) begin
					if (cb[mcnt_q]) begin
						prod_q <= prod_q + (33'(mcand_q) << mcnt_q);
					end
					mcnt_q <= mcnt_q + 1'b1;
				end
				mpos_q <= mcand_q[PW-1:0];
				mlen_q <= quo_q[LW-1:0];
				mset_q <= 1'b1;
			end
			bffa_pkg::S_CHK:
				if (!heap_over) begin
					eaddr_q[slot_q] <= endsum[31:0];
					estart_q[slot_q] <= mpos_q;
					elen_q[slot_q] <= mlen_q;
				end
			bffa_pkg::S_MARK: begin
				mpos_q <= mpos_q + 1'b1;
				mlen_q <= mlen_q - 1'b1;
			end
			bffa_pkg::S_FSCAN: begin
				slot_q <= tcnt_q[TW-1:0];
				tcnt_q <= tcnt_q + 1'b1;
			end
			bffa_pkg::S_FRD: begin
				mpos_q <= estart_q[slot_q];
				mlen_q <= elen_q[slot_q];
				mset_q <= 1'b0;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
